// ===== rtl/tcw_pkg.sv =====
// tcw_pkg: shared types and constants of the text console writer
// field widths, stream packing, character codes and sequencer states
// no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int INDEX_W    = 11;
    localparam int CURSOR_W   = 11;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_BLANK
    } state_t;

endpackage

// ===== rtl/text_console_writer_unit.sv =====
// text_console_writer_unit: text console with screen store, cursor and scroll
// one sequencer drives a single-port-write, single-port-read screen memory
// depends on tcw_pkg
`timescale 1ns / 1ps

// put without scroll: result registered in the cycle after accept; read: cell
//   passes rd_data_reg, then the output register; put that scrolls: ST_COPY moves
//   each row up by one, ST_BLANK blanks the last row (one cell copied or blanked per cycle
//   on the memory write port); input is taken only in ST_IDLE, when the output
//   register is empty or being read; reset: cursor zero, attribute 0x0F, then a
//   clearing pass zeroes the screen memory while s_axis_tready stays low
module text_console_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // char_code [7:0], cell_index [18:8], zero [23:19]
    input  logic [tcw_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // op [0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // cell_char [7:0], cell_attr [15:8], cursor [26:16], scrolled [27], zero [31:28]
    output logic [tcw_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = $clog2(CELLS + 1);
    localparam int CLW   = $clog2(COLUMNS);

    state_t state_reg, state_next;

    logic [PW-1:0]         cursor_reg, cursor_next;
    logic [CLW-1:0]        col_reg, col_next;
    logic [PW-1:0]         ptr_reg, ptr_next;
    logic [AW-1:0]         wptr_reg, wptr_next;
    logic                  pend_reg, pend_next;
    logic                  hit_reg, hit_next;
    logic [ATTR_W-1:0]     attr_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [CELL_W-1:0]     rd_data_reg;
    logic [CELL_W-1:0]     mem [CELLS];

    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [CELL_W-1:0]     mem_wdata;

    logic                  in_accept, out_pop;
    logic [CHAR_W-1:0]     in_char;
    logic [INDEX_W-1:0]    in_index;
    logic                  is_newline, in_range;
    logic [PW:0]           put_sum;
    logic                  scroll_hit;
    logic [PW-1:0]         put_cursor;
    logic                  ptr_at_end, ptr_at_last;

    assign pready = 1'b1;
    assign prdata = APB_DATA_W'(attr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    assign in_char    = s_axis_tdata[CHAR_W-1:0];
    assign in_index   = s_axis_tdata[CHAR_W+INDEX_W-1:CHAR_W];
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_pop    = out_valid_reg && m_axis_tready;
    assign is_newline = (in_char == NEWLINE_CHAR);
    assign in_range   = (32'(in_index) < 32'(CELLS));

    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign put_sum = is_newline
        ? {1'b0, cursor_reg} + (PW+1)'(COLUMNS) - (PW+1)'(col_reg)
        : {1'b0, cursor_reg} + (PW+1)'(1);
    assign scroll_hit = (put_sum >= (PW+1)'(CELLS));
    assign put_cursor = scroll_hit ? PW'(put_sum - (PW+1)'(COLUMNS)) : PW'(put_sum);

    assign ptr_at_end  = (ptr_reg == PW'(CELLS));
    assign ptr_at_last = (ptr_reg == PW'(CELLS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (ptr_at_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser == OP_READ)
                        state_next = ST_READ;
                    else if (scroll_hit)
                        state_next = ST_COPY;
                end
            end
            ST_READ:
                state_next = ST_IDLE;
            ST_COPY:
            begin
                if (ptr_at_end)
                    state_next = ST_BLANK;
            end
            ST_BLANK:
            begin
                if (ptr_at_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cursor_next   = cursor_reg;
        col_next      = col_reg;
        ptr_next      = ptr_reg;
        wptr_next     = wptr_reg;
        pend_next     = pend_reg;
        hit_next      = hit_reg;
        out_data_next = out_data_reg;
        out_valid_next = out_pop ? 1'b0 : out_valid_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = AW'(ptr_reg);
        mem_raddr = AW'(ptr_reg);
        mem_wdata = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(ptr_reg);
                mem_wdata = '0;
                ptr_next  = ptr_at_last ? '0 : ptr_reg + PW'(1);
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser == OP_READ)
                    begin
                        hit_next  = in_range;
                        mem_re    = in_range;
                        mem_raddr = AW'(in_index);
                    end
                    else
                    begin
                        cursor_next = put_cursor;
                        if (is_newline)
                        begin
                            col_next = '0;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(cursor_reg);
                            mem_wdata = {attr_reg, in_char};
                            col_next  = (col_reg == CLW'(COLUMNS - 1))
                                        ? '0 : col_reg + CLW'(1);
                        end
                        if (scroll_hit)
                        begin
                            ptr_next  = PW'(COLUMNS);
                            pend_next = 1'b0;
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = {4'b0, 1'b0, CURSOR_W'(put_cursor),
                                              {ATTR_W{1'b0}}, {CHAR_W{1'b0}}};
                        end
                    end
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_data_next  = {4'b0, 1'b0, CURSOR_W'(cursor_reg),
                                  hit_reg ? rd_data_reg : {CELL_W{1'b0}}};
            end
            ST_COPY:
            begin
                // read one row below; the cell is written one row up in the next cycle
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wptr_reg;
                    mem_wdata = rd_data_reg;
                end
                if (ptr_at_end)
                begin
                    ptr_next  = PW'(CELLS - COLUMNS);
                    pend_next = 1'b0;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(ptr_reg);
                    wptr_next = AW'(ptr_reg - PW'(COLUMNS));
                    pend_next = 1'b1;
                    ptr_next  = ptr_reg + PW'(1);
                end
            end
            ST_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(ptr_reg);
                mem_wdata = {attr_reg, BLANK_CHAR};
                ptr_next  = ptr_reg + PW'(1);
                if (ptr_at_last)
                begin
                    ptr_next       = '0;
                    out_valid_next = 1'b1;
                    out_data_next  = {4'b0, 1'b1, CURSOR_W'(cursor_reg),
                                      {ATTR_W{1'b0}}, {CHAR_W{1'b0}}};
                end
            end
            default:
            begin
                ptr_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cursor_reg    <= '0;
            col_reg       <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wptr_reg     <= wptr_next;
        out_data_reg <= out_data_next;
    end

    // screen memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

endmodule

// ===== rtl/tcw_checker.sv =====
// tcw_checker: port-level checks of the text console writer
// bound to text_console_writer_unit; depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [tcw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    logic [CURSOR_W-1:0] out_cursor;
    logic                out_scrolled;

    assign out_cursor   = m_axis_tdata[CURSOR_W+CELL_W-1:CELL_W];
    assign out_scrolled = m_axis_tdata[CURSOR_W+CELL_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_scroll_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_scrolled |-> m_axis_tdata[CELL_W-1:0] == '0)
        else $error("scroll result carries cell data");

    a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_scrolled && (CELLS < 2048)
        |-> 32'(out_cursor) >= 32'(CELLS - COLUMNS) && 32'(out_cursor) < 32'(CELLS))
        else $error("cursor not on last row after scroll");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_READ
        |=> !m_axis_tvalid ##1 m_axis_tvalid && !out_scrolled)
        else $error("read result not delivered two cycles after accept");

endmodule

bind text_console_writer_unit tcw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
) u_tcw_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
